// ===== src/rsm_pkg.sv =====
`timescale 1ns / 1ps
package rsm_pkg;

   // field widths
   localparam int SectW  = 48;
   localparam int LenW   = 16;
   localparam int ChunkW = 20;
   localparam int DevW   = 5;
   localparam int MembW  = 4;

   // half width used to split the stripe multiply
   localparam int HalfW  = SectW / 2;

   // csr port
   localparam int CsrIdxW  = 3;
   localparam int CsrDataW = 48;

   // csr register indexes
   localparam logic [CsrIdxW-1:0] RegChunk      = 3'd0;
   localparam logic [CsrIdxW-1:0] RegZone0End   = 3'd1;
   localparam logic [CsrIdxW-1:0] RegZone0Devs  = 3'd2;
   localparam logic [CsrIdxW-1:0] RegZone1End   = 3'd3;
   localparam logic [CsrIdxW-1:0] RegZone1Devs  = 3'd4;
   localparam logic [CsrIdxW-1:0] RegZone1Start = 3'd5;

   // sideband carried next to the first divider pair
   typedef struct packed {
      logic            oor;
      logic            zone;
      logic [LenW-1:0] len;
   } side_a_type;

   // sideband carried next to the member divider
   typedef struct packed {
      logic              oor;
      logic              zone;
      logic [ChunkW-1:0] in_chunk;
      logic [LenW-1:0]   piece;
      logic              split;
   } side_b_type;

endpackage

// ===== src/rsm_div.sv =====
`timescale 1ns / 1ps
module rsm_div #(
   parameter int DW = 48,
   parameter int VW = 20
) (
   input  logic          clock,
   input  logic          en,
   input  logic [DW-1:0] dividend,
   input  logic [VW-1:0] divisor,
   output logic [DW-1:0] quotient,
   output logic [VW-1:0] remainder
);

   // one quotient bit per stage, restoring
   logic [VW-1:0] rem_ff  [DW];
   logic [DW-1:0] work_ff [DW];
   logic [VW-1:0] div_ff  [DW-1];

   for (genvar k = 0; k < DW; k++) begin : g_stage
      logic [VW-1:0] rem_src;
      logic [DW-1:0] work_src;
      logic [VW-1:0] div_src;
      logic [VW:0]   trial;
      logic [VW:0]   diff;
      logic          ge;

      if (k == 0) begin : g_first
         assign rem_src  = '0;
         assign work_src = dividend;
         assign div_src  = divisor;
      end else begin : g_next
         assign rem_src  = rem_ff[k-1];
         assign work_src = work_ff[k-1];
         assign div_src  = div_ff[k-1];
      end

      // shift in next dividend bit and try the subtract
      assign trial = {rem_src, work_src[DW-1]};
      assign diff  = trial - {1'b0, div_src};
      assign ge    = (trial >= {1'b0, div_src});

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[k]  <= ge ? diff[VW-1:0] : trial[VW-1:0];
            work_ff[k] <= {work_src[DW-2:0], ge};
         end
      end

      if (k < DW - 1) begin : g_div
         always_ff @(posedge clock) begin
            if (en) begin
               div_ff[k] <= div_src;
            end
         end
      end
   end

   assign quotient  = work_ff[DW-1];
   assign remainder = rem_ff[DW-1];

endmodule

// ===== src/rsm_delay.sv =====
`timescale 1ns / 1ps
module rsm_delay #(
   parameter int W = 8,
   parameter int D = 4
) (
   input  logic         clock,
   input  logic         en,
   input  logic [W-1:0] din,
   output logic [W-1:0] dout
);

   // shift line matching divider latency
   logic [W-1:0] tap_ff [D];

   always_ff @(posedge clock) begin
      if (en) begin
         tap_ff[0] <= din;
         for (int i = 1; i < D; i++) begin
            tap_ff[i] <= tap_ff[i-1];
         end
      end
   end

   assign dout = tap_ff[D-1];

endmodule

// ===== src/raid0_stripe_sector_mapper.sv =====
`timescale 1ns / 1ps
// request path: input register, two divider chains, product register, result register
// one request per cycle unless frozen; two 48-stage divider chains set the depth
// the whole pipeline freezes while a result word is held by rsp_stall
// reset: synchronous, clears valid bits and loads csr defaults (chunk 128, zone0 one member)
module raid0_stripe_sector_mapper #(
   parameter int MAX_DEVICES = 16,
   parameter int SECTOR_BITS = 48
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic [rsm_pkg::SectW-1:0]      req_logical_sector,
   input  logic [rsm_pkg::LenW-1:0]       req_request_sectors,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic                           rsp_out_of_range,
   output logic                           rsp_zone_index,
   output logic [rsm_pkg::MembW-1:0]      rsp_member_index,
   output logic [rsm_pkg::SectW-1:0]      rsp_device_sector,
   output logic [rsm_pkg::LenW-1:0]       rsp_piece_sectors,
   output logic                           rsp_was_split,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [rsm_pkg::CsrIdxW-1:0]    csr_index,
   input  logic [rsm_pkg::CsrDataW-1:0]   csr_data
);
   import rsm_pkg::*;

   localparam int Lat      = 2 * SectW + 3;
   localparam int KeepBits = (SECTOR_BITS < SectW) ? SECTOR_BITS : SectW;
   localparam logic [SectW-1:0] SectMask = (SectW'(1) << KeepBits) - SectW'(1);

   // csr registers
   logic [ChunkW-1:0] chunk_ff;
   logic [SectW-1:0]  zone0_end_ff;
   logic [DevW-1:0]   zone0_devs_ff;
   logic [SectW-1:0]  zone1_end_ff;
   logic [DevW-1:0]   zone1_devs_ff;
   logic [SectW-1:0]  zone1_start_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         chunk_ff       <= ChunkW'(128);
         zone0_end_ff   <= '0;
         zone0_devs_ff  <= DevW'(1);
         zone1_end_ff   <= '0;
         zone1_devs_ff  <= '0;
         zone1_start_ff <= '0;
      end else if (csr_valid) begin
         case (csr_index)
            RegChunk:      chunk_ff       <= csr_data[ChunkW-1:0];
            RegZone0End:   zone0_end_ff   <= csr_data[SectW-1:0];
            RegZone0Devs:  zone0_devs_ff  <= csr_data[DevW-1:0];
            RegZone1End:   zone1_end_ff   <= csr_data[SectW-1:0];
            RegZone1Devs:  zone1_devs_ff  <= csr_data[DevW-1:0];
            RegZone1Start: zone1_start_ff <= csr_data[SectW-1:0];
            default: ;
         endcase
      end
   end

   // global advance: hold everything while the result word waits
   logic en;
   logic [Lat-1:0] vld_ff;

   assign en        = !(vld_ff[Lat-1] && rsp_stall);
   assign req_stall = !en;
   assign rsp_valid = vld_ff[Lat-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[Lat-2:0], req_valid};
      end
   end

   // zone lookup
   logic             in_z0;
   logic             in_z1;
   logic [DevW-1:0]  in_devs;
   logic             in_oor;
   logic [SectW-1:0] s0_zs_in;

   assign in_z0    = (req_logical_sector < zone0_end_ff);
   assign in_z1    = (zone1_devs_ff != '0) && (req_logical_sector < zone1_end_ff);
   assign in_devs  = in_z0 ? zone0_devs_ff : zone1_devs_ff;
   assign in_oor   = !(in_z0 || in_z1) || (chunk_ff == '0) || (in_devs == '0) ||
                     (32'(in_devs) > MAX_DEVICES);
   assign s0_zs_in = in_z0 ? req_logical_sector : (req_logical_sector - zone0_end_ff);

   logic [SectW-1:0] s0_zs_ff;
   logic [SectW-1:0] s0_sector_ff;
   side_a_type       s0_side_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         s0_zs_ff        <= s0_zs_in;
         s0_sector_ff    <= req_logical_sector;
         s0_side_ff.oor  <= in_oor;
         s0_side_ff.zone <= !in_z0 && in_z1;
         s0_side_ff.len  <= req_request_sectors;
      end
   end

   // zone sector by chunk, logical sector modulo chunk
   logic [SectW-1:0]  chunk_no;
   logic [ChunkW-1:0] in_chunk;
   logic [SectW-1:0]  lq_unused;
   logic [ChunkW-1:0] lrem;
   side_a_type        d1_side;

   rsm_div #(.DW(SectW), .VW(ChunkW)) u_div_zs (
      .clock     (clock),
      .en        (en),
      .dividend  (s0_zs_ff),
      .divisor   (chunk_ff),
      .quotient  (chunk_no),
      .remainder (in_chunk)
   );

   rsm_div #(.DW(SectW), .VW(ChunkW)) u_div_lsec (
      .clock     (clock),
      .en        (en),
      .dividend  (s0_sector_ff),
      .divisor   (chunk_ff),
      .quotient  (lq_unused),
      .remainder (lrem)
   );

   rsm_delay #(.W($bits(side_a_type)), .D(SectW)) u_dly_a (
      .clock (clock),
      .en    (en),
      .din   (s0_side_ff),
      .dout  (d1_side)
   );

   // chunk clipping
   logic [ChunkW-1:0] remain;
   logic              clip;
   logic [DevW-1:0]   d1_devs;
   side_b_type        d1_side_b;
   side_b_type        d2_side;

   assign remain  = chunk_ff - lrem;
   assign clip    = (chunk_ff != '0) && (remain < ChunkW'(d1_side.len));
   assign d1_devs = d1_side.zone ? zone1_devs_ff : zone0_devs_ff;

   always_comb begin
      d1_side_b.oor      = d1_side.oor;
      d1_side_b.zone     = d1_side.zone;
      d1_side_b.in_chunk = in_chunk;
      d1_side_b.piece    = clip ? remain[LenW-1:0] : d1_side.len;
      d1_side_b.split    = clip;
   end

   // chunk number by device count: stripe and member
   logic [SectW-1:0] stripe;
   logic [DevW-1:0]  member;

   rsm_div #(.DW(SectW), .VW(DevW)) u_div_dev (
      .clock     (clock),
      .en        (en),
      .dividend  (chunk_no),
      .divisor   (d1_devs),
      .quotient  (stripe),
      .remainder (member)
   );

   rsm_delay #(.W($bits(side_b_type)), .D(SectW)) u_dly_b (
      .clock (clock),
      .en    (en),
      .din   (d1_side_b),
      .dout  (d2_side)
   );

   // stripe times chunk in two partial products
   logic [HalfW+ChunkW-1:0] pp_lo_ff;
   logic [HalfW-1:0]        pp_hi_ff;
   logic [HalfW+ChunkW-1:0] pp_hi_in;
   logic [MembW-1:0]        m1_member_ff;
   side_b_type              m1_side_ff;

   assign pp_hi_in = stripe[SectW-1:HalfW] * chunk_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         pp_lo_ff     <= stripe[HalfW-1:0] * chunk_ff;
         pp_hi_ff     <= pp_hi_in[HalfW-1:0];
         m1_member_ff <= member[MembW-1:0];
         m1_side_ff   <= d2_side;
      end
   end

   // device sector sum and result word
   logic [SectW-1:0] start;
   logic [SectW-1:0] dsect_in;

   assign start    = m1_side_ff.zone ? zone1_start_ff : '0;
   assign dsect_in = ({pp_hi_ff, HalfW'(0)} + SectW'(pp_lo_ff) +
                      SectW'(m1_side_ff.in_chunk) + start) & SectMask;

   logic             oor_ff;
   logic             zone_ff;
   logic [MembW-1:0] member_ff;
   logic [SectW-1:0] dsect_ff;
   logic [LenW-1:0]  piece_ff;
   logic             split_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         oor_ff    <= m1_side_ff.oor;
         zone_ff   <= m1_side_ff.oor ? 1'b0 : m1_side_ff.zone;
         member_ff <= m1_side_ff.oor ? '0 : m1_member_ff;
         dsect_ff  <= m1_side_ff.oor ? '0 : dsect_in;
         piece_ff  <= m1_side_ff.piece;
         split_ff  <= m1_side_ff.split;
      end
   end

   assign rsp_out_of_range  = oor_ff;
   assign rsp_zone_index    = zone_ff;
   assign rsp_member_index  = member_ff;
   assign rsp_device_sector = dsect_ff;
   assign rsp_piece_sectors = piece_ff;
   assign rsp_was_split     = split_ff;

endmodule
